// ----- sv/utf8d_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int CP_W          = 21;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [CP_W-1:0] MARK_CP = 21'h00003F;  // '?'

  // lead byte classes, matched against the top bits of the byte
  localparam logic [1:0] CONT_TAG  = 2'b10;
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       flush;
  } in_item_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            replaced;
    logic            last_of_run;
  } out_item_t;

  // work for the back end: a run of '?' marks, then an optional final result
  typedef struct packed {
    logic [1:0]      marks;
    logic            has_tail;
    logic [CP_W-1:0] tail_cp;
    logic            tail_rep;
  } job_t;

endpackage
`default_nettype wire

// ----- sv/utf8d_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_front
// Byte classifier and sequence tracker; turns each byte that causes a result into one job.
// ----------------------------------------------------------------------------
module utf8d_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  utf8d_pkg::in_item_t    in_data,
  output logic                   push,
  output utf8d_pkg::job_t        job
);

  logic                       pending_r, pending_nxt;
  logic [1:0]                 needed_r, needed_nxt;
  logic [1:0]                 held_r, held_nxt;
  logic [utf8d_pkg::CP_W-1:0] acc_r, acc_nxt;

  logic [7:0]                 b;
  logic [1:0]                 needed_dec;
  logic [utf8d_pkg::CP_W-1:0] acc_shift;
  logic                       accept;

  assign b          = in_data.data_byte;
  assign needed_dec = needed_r - 2'd1;
  assign acc_shift  = {acc_r[utf8d_pkg::CP_W-7:0], b[5:0]};
  assign accept     = in_valid && !in_stall;

  always_comb begin
    pending_nxt  = pending_r;
    needed_nxt   = needed_r;
    held_nxt     = held_r;
    acc_nxt      = acc_r;
    job.marks    = 2'd0;
    job.has_tail = 1'b0;
    job.tail_cp  = utf8d_pkg::MARK_CP;
    job.tail_rep = 1'b0;
    if (in_data.flush) begin
      job.marks   = pending_r ? held_r : 2'd0;
      pending_nxt = 1'b0;
      needed_nxt  = 2'd0;
      held_nxt    = 2'd0;
      acc_nxt     = '0;
    end else if (pending_r && (b[7:6] == utf8d_pkg::CONT_TAG)) begin
      if (needed_dec == 2'd0) begin
        job.has_tail = 1'b1;
        job.tail_cp  = acc_shift;
        pending_nxt  = 1'b0;
        needed_nxt   = 2'd0;
        held_nxt     = 2'd0;
        acc_nxt      = '0;
      end else begin
        needed_nxt = needed_dec;
        held_nxt   = held_r + 2'd1;
        acc_nxt    = acc_shift;
      end
    end else begin
      // broken sequence: held bytes become marks, byte handled afresh
      job.marks   = pending_r ? held_r : 2'd0;
      pending_nxt = 1'b0;
      needed_nxt  = 2'd0;
      held_nxt    = 2'd0;
      acc_nxt     = '0;
      if (!b[7]) begin
        job.has_tail = 1'b1;
        job.tail_cp  = {{(utf8d_pkg::CP_W-8){1'b0}}, b};
      end else if (b[7:5] == utf8d_pkg::LEAD2_TAG) begin
        pending_nxt = 1'b1;
        needed_nxt  = 2'd1;
        held_nxt    = 2'd1;
        acc_nxt     = {{(utf8d_pkg::CP_W-5){1'b0}}, b[4:0]};
      end else if (b[7:4] == utf8d_pkg::LEAD3_TAG) begin
        pending_nxt = 1'b1;
        needed_nxt  = 2'd2;
        held_nxt    = 2'd1;
        acc_nxt     = {{(utf8d_pkg::CP_W-4){1'b0}}, b[3:0]};
      end else if (b[7:3] == utf8d_pkg::LEAD4_TAG) begin
        pending_nxt = 1'b1;
        needed_nxt  = 2'd3;
        held_nxt    = 2'd1;
        acc_nxt     = {{(utf8d_pkg::CP_W-3){1'b0}}, b[2:0]};
      end else begin
        job.has_tail = 1'b1;
        job.tail_cp  = utf8d_pkg::MARK_CP;
        job.tail_rep = 1'b1;
      end
    end
  end

  // items that cause no result never enter the queue
  assign push = accept && ((job.marks != 2'd0) || job.has_tail);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      needed_r  <= 2'd0;
      held_r    <= 2'd0;
      acc_r     <= '0;
    end else if (accept) begin
      pending_r <= pending_nxt;
      needed_r  <= needed_nxt;
      held_r    <= held_nxt;
      acc_r     <= acc_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/utf8d_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_queue
// Small first-in first-out job queue between front and back end.
// ----------------------------------------------------------------------------
module utf8d_queue #(
  parameter int DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  utf8d_pkg::job_t      push_data,
  input  wire logic            pop,
  output utf8d_pkg::job_t      head,
  output logic                 empty,
  output logic                 full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  utf8d_pkg::job_t   mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/utf8d_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_back
// Expands queued jobs into result transactions, one per cycle while jobs wait and out_stall is low.
// ----------------------------------------------------------------------------
module utf8d_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  utf8d_pkg::job_t      head,
  input  wire logic            empty,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output utf8d_pkg::out_item_t out_data
);

  logic                  out_valid_r, out_valid_nxt;
  utf8d_pkg::out_item_t  out_data_r, out_data_nxt;
  logic [1:0]            sent_r, sent_nxt;
  logic [1:0]            sent_inc;
  logic                  load;

  assign load     = (!out_valid_r || !out_stall) && !empty;
  assign sent_inc = sent_r + 2'd1;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    sent_nxt      = sent_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (sent_r < head.marks) begin
        out_data_nxt.code_point  = utf8d_pkg::MARK_CP;
        out_data_nxt.replaced    = 1'b1;
        out_data_nxt.last_of_run = (sent_inc == head.marks) && !head.has_tail;
        if ((sent_inc == head.marks) && !head.has_tail) begin
          pop      = 1'b1;
          sent_nxt = 2'd0;
        end else begin
          sent_nxt = sent_inc;
        end
      end else begin
        out_data_nxt.code_point  = head.tail_cp;
        out_data_nxt.replaced    = head.tail_rep;
        out_data_nxt.last_of_run = 1'b1;
        pop                      = 1'b1;
        sent_nxt                 = 2'd0;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sent_r      <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sent_r      <= sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ----- sv/utf8_stream_decoder_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// UTF-8 byte stream to code point decoder.
// ----------------------------------------------------------------------------
// One byte (or flush) transaction is taken per clock while in_stall is low. The
// front end tracks the open sequence and hands the work of each byte that causes
// a result to a job queue (QUEUE_DEPTH jobs); the registered back end emits one
// result per clock while jobs wait and out_stall is low. A broken sequence or
// flush can cause up to 4 results, and in_stall rises only once the queue is
// full. Results pass through the job queue and the back end's output register.
// Invalid or truncated bytes give '?' with replaced set, and last_of_run marks
// the final result of each input transaction.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top #(
  parameter int QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  utf8d_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output utf8d_pkg::out_item_t out_data
);

  utf8d_pkg::job_t push_job;
  utf8d_pkg::job_t head_job;
  logic            push;
  logic            pop;
  logic            q_empty;
  logic            q_full;

  assign in_stall = q_full;

  utf8d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .job      (push_job)
  );

  utf8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_job),
    .pop       (pop),
    .head      (head_job),
    .empty     (q_empty),
    .full      (q_full)
  );

  utf8d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head_job),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- sim/utf8_stream_decoder_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top_tb
// Self-checking bench for the UTF-8 stream decoder. Byte and flush
// transactions go through a bit-level model of the decoder, and every result
// is checked field by field against the oldest predicted code point. A short
// directed list is followed by mostly well-formed random sequences, with
// random gaps and stalls, one long result hold-off and one drain pause.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top_tb;

  localparam int FLUSH_CODE       = 'h100;
  localparam int RANDOM_ITEMS     = 450;
  localparam int HOLD_AT          = 150;
  localparam int DRAIN_AT         = 300;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES      = 20;
  localparam int CYCLE_LIMIT      = 200000;

  class cp_scoreboard;
    logic                       seq_open;
    logic [1:0]                 cont_left;
    logic [1:0]                 held_cnt;
    logic [utf8d_pkg::CP_W-1:0] acc;
    utf8d_pkg::out_item_t       pending_cps[$];
    int                         errors;

    function new();
      errors = 0;
      close_seq();
    endfunction

    function void close_seq();
      seq_open  = 1'b0;
      cont_left = '0;
      held_cnt  = '0;
      acc       = '0;
    endfunction

    function void add_cp(logic [utf8d_pkg::CP_W-1:0] cp, logic rep);
      utf8d_pkg::out_item_t r;
      r.code_point  = cp;
      r.replaced    = rep;
      r.last_of_run = 1'b0;
      pending_cps.insert(pending_cps.size(), r);
    endfunction

    // every byte of the open sequence turns into a '?'
    function void dump_held();
      for (int i = 0; i < held_cnt; i++) add_cp(utf8d_pkg::MARK_CP, 1'b1);
      close_seq();
    endfunction

    function void open_seq(logic [1:0] need, logic [utf8d_pkg::CP_W-1:0] bits);
      seq_open  = 1'b1;
      cont_left = need;
      held_cnt  = 2'd1;
      acc       = bits;
    endfunction

    function void start_byte(logic [7:0] b);
      if (!b[7]) add_cp((utf8d_pkg::CP_W)'(b), 1'b0);
      else if (b[7:5] == utf8d_pkg::LEAD2_TAG) open_seq(2'd1, (utf8d_pkg::CP_W)'(b[4:0]));
      else if (b[7:4] == utf8d_pkg::LEAD3_TAG) open_seq(2'd2, (utf8d_pkg::CP_W)'(b[3:0]));
      else if (b[7:3] == utf8d_pkg::LEAD4_TAG) open_seq(2'd3, (utf8d_pkg::CP_W)'(b[2:0]));
      else add_cp(utf8d_pkg::MARK_CP, 1'b1);
    endfunction

    function void decode_byte_item(utf8d_pkg::in_item_t it);
      int                   start;
      utf8d_pkg::out_item_t tail;
      start = pending_cps.size();
      if (it.flush) begin
        dump_held();
      end else if (seq_open && it.data_byte[7:6] == utf8d_pkg::CONT_TAG) begin
        acc       = {acc[utf8d_pkg::CP_W-7:0], it.data_byte[5:0]};
        held_cnt  = held_cnt + 2'd1;
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          add_cp(acc, 1'b0);
          close_seq();
        end
      end else begin
        // a broken sequence is dumped, then the byte is taken afresh
        if (seq_open) dump_held();
        start_byte(it.data_byte);
      end
      if (pending_cps.size() > start) begin
        tail = pending_cps.pop_back();
        tail.last_of_run = 1'b1;
        pending_cps.insert(pending_cps.size(), tail);
      end
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_code_point(utf8d_pkg::out_item_t got);
      utf8d_pkg::out_item_t want;
      if (pending_cps.size() == 0) begin
        report_mismatch($sformatf("result cp=%h with nothing pending", got.code_point));
        return;
      end
      want = pending_cps.pop_front();
      if (got.code_point !== want.code_point)
        report_mismatch($sformatf("code_point %h, want %h", got.code_point, want.code_point));
      if (got.replaced !== want.replaced)
        report_mismatch($sformatf("replaced %b, want %b (cp %h)", got.replaced,
                                  want.replaced, want.code_point));
      if (got.last_of_run !== want.last_of_run)
        report_mismatch($sformatf("last_of_run %b, want %b (cp %h)", got.last_of_run,
                                  want.last_of_run, want.code_point));
    endtask
  endclass

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  utf8d_pkg::in_item_t  in_data    = '0;
  logic                 out_valid;
  logic                 out_stall;
  utf8d_pkg::out_item_t out_data;

  logic      sink_stall = 1'b0;
  logic      hold_off   = 1'b0;
  logic      hold_req   = 1'b0;
  logic      gaps_on    = 1'b1;
  logic      stalls_on  = 1'b1;
  int        cycle_cnt  = 0;

  cp_scoreboard        sb;
  utf8d_pkg::in_item_t run_q[$];

  assign out_stall = sink_stall | hold_off;

  utf8_stream_decoder_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_code_point(out_data);
  end

  // result side: random stall before each transaction
  initial begin : result_sink
    int n;
    wait (rst_n);
    forever begin
      @(negedge clk);
      n = stalls_on ? $urandom_range(0, 9) : 0;
      if (n > 0) begin
        sink_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      sink_stall = 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // one long hold-off so the job queue fills and in_stall rises
  initial begin : long_hold
    wait (hold_req);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (LONG_HOLD_CYCLES) @(negedge clk);
    hold_off = 1'b0;
    hold_req = 1'b0;
  end

  task automatic send_item(input utf8d_pkg::in_item_t it);
    int gap;
    gap = (gaps_on && !hold_req) ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = it;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.decode_byte_item(it);
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_cps.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic utf8d_pkg::in_item_t byte_item(logic [7:0] b);
    utf8d_pkg::in_item_t it;
    it.data_byte = b;
    it.flush     = 1'b0;
    return it;
  endfunction

  function automatic logic [7:0] lead_byte(int len);
    case (len)
      2:       return {utf8d_pkg::LEAD2_TAG, 5'($urandom)};
      3:       return {utf8d_pkg::LEAD3_TAG, 4'($urandom)};
      default: return {utf8d_pkg::LEAD4_TAG, 3'($urandom)};
    endcase
  endfunction

  // one random run: mostly complete sequences, some noise
  function automatic void fill_run();
    int                  pick;
    int                  len;
    int                  conts;
    utf8d_pkg::in_item_t it;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      run_q.insert(run_q.size(), byte_item(8'($urandom_range(0, 127))));
    end else if (pick < 82) begin
      len   = (pick < 45) ? 2 : (pick < 60) ? 3 : (pick < 75) ? 4 : $urandom_range(2, 4);
      conts = (pick < 75) ? len - 1 : $urandom_range(0, len - 2);
      run_q.insert(run_q.size(), byte_item(lead_byte(len)));
      for (int i = 0; i < conts; i++)
        run_q.insert(run_q.size(), byte_item({utf8d_pkg::CONT_TAG, 6'($urandom)}));
    end else if (pick < 88) begin
      it.data_byte = 8'($urandom);
      it.flush     = 1'b1;
      run_q.insert(run_q.size(), it);
    end else if (pick < 94) begin
      run_q.insert(run_q.size(), byte_item({utf8d_pkg::CONT_TAG, 6'($urandom)}));
    end else begin
      run_q.insert(run_q.size(), byte_item(8'($urandom)));
    end
  endfunction

  initial begin : stimulus
    int                  dir_seq[$];
    int                  sent;
    logic                hold_done;
    logic                drain_done;
    utf8d_pkg::in_item_t it;
    dir_seq = '{'h00, 'h7F, 'hE2, 'h82, 'hAC, 'hF0, 'h9F, 'h98, 'h80, 'h80, 'hF8,
                'hC0, 'h80, 'hED, 'hA0, 'h80, 'hF7, 'hBF, 'h41, 'hF0, 'h9F, 'h98,
                'hFF, 'hE2, FLUSH_CODE, FLUSH_CODE};
    sent       = 0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_seq[i]) begin
      it.flush     = (dir_seq[i] == FLUSH_CODE);
      it.data_byte = it.flush ? 8'($urandom) : dir_seq[i][7:0];
      send_item(it);
    end
    wait_all_results();

    while (sent < RANDOM_ITEMS) begin
      if (sent % 60 == 0) begin
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      if (!hold_done && sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
      if (!drain_done && sent >= DRAIN_AT) begin
        drain_done = 1'b1;
        wait_all_results();
      end
      fill_run();
      while (run_q.size() != 0) begin
        send_item(run_q.pop_front());
        sent++;
      end
    end
    wait_all_results();

    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
